// File: rtl/core/ccrc_pkg.sv
// Shared types, register indexes and bit-reversal helpers for the CRC engine.
`timescale 1ns / 1ps

package ccrc_pkg;

  localparam int unsigned CrcW     = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned WidthRegW = 7;
  localparam int unsigned ShamtW   = 6;

  // Configuration register indexes; index 7 is unused and ignored on write.
  typedef enum logic [CfgIdxW-1:0] {
    REG_CRC_WIDTH      = 3'd0,
    REG_POLY_VALUE     = 3'd1,
    REG_REFLECTED_MODE = 3'd2,
    REG_INIT_VALUE     = 3'd3,
    REG_REFLECT_IN     = 3'd4,
    REG_REFLECT_OUT    = 3'd5,
    REG_XOR_OUT        = 3'd6
  } ccrc_reg_e;

  // Settings in the form the datapath uses them, already reduced to the width.
  typedef struct packed {
    logic [ShamtW-1:0] shamt;      // 64 minus the effective width
    logic [CrcW-1:0]   mask;       // ones below the effective width
    logic [CrcW-1:0]   poly_fwd;   // polynomial aligned to the top of 64 bits
    logic [CrcW-1:0]   poly_ref;   // polynomial bit-reversed within the width
    logic [CrcW-1:0]   init_m;     // initial value within the width
    logic [CrcW-1:0]   xor_m;      // output mask within the width
    logic              reflected;
    logic              refl_in;
    logic              refl_out;
  } ccrc_cfg_t;

  function automatic logic [ByteW-1:0] bit_rev8(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] bit_rev64(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ccrc_cfg.sv
// Configuration registers and the registered settings derived from them.
`timescale 1ns / 1ps

module ccrc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccrc_pkg::CrcW-1:0]     cfg_wdata_i,
  output ccrc_pkg::ccrc_cfg_t           cfg_o
);

  logic [ccrc_pkg::WidthRegW-1:0] crc_width_q;
  logic [ccrc_pkg::CrcW-1:0]      poly_value_q;
  logic                           reflected_mode_q;
  logic [ccrc_pkg::CrcW-1:0]      init_value_q;
  logic                           reflect_in_q;
  logic                           reflect_out_q;
  logic [ccrc_pkg::CrcW-1:0]      xor_out_q;

  logic [ccrc_pkg::WidthRegW-1:0] w_eff;
  logic [ccrc_pkg::WidthRegW-1:0] shamt_full;
  ccrc_pkg::ccrc_cfg_t            cfg_d;
  ccrc_pkg::ccrc_cfg_t            cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_width_q      <= 7'd16;
      poly_value_q     <= 64'h8005;
      reflected_mode_q <= 1'b1;
      init_value_q     <= 64'hFFFF;
      reflect_in_q     <= 1'b0;
      reflect_out_q    <= 1'b0;
      xor_out_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccrc_pkg::REG_CRC_WIDTH:      crc_width_q      <= cfg_wdata_i[ccrc_pkg::WidthRegW-1:0];
        ccrc_pkg::REG_POLY_VALUE:     poly_value_q     <= cfg_wdata_i;
        ccrc_pkg::REG_REFLECTED_MODE: reflected_mode_q <= cfg_wdata_i[0];
        ccrc_pkg::REG_INIT_VALUE:     init_value_q     <= cfg_wdata_i;
        ccrc_pkg::REG_REFLECT_IN:     reflect_in_q     <= cfg_wdata_i[0];
        ccrc_pkg::REG_REFLECT_OUT:    reflect_out_q    <= cfg_wdata_i[0];
        ccrc_pkg::REG_XOR_OUT:        xor_out_q        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Widths outside 8..64 are clamped to the nearest end.
  always_comb begin
    if (crc_width_q < 7'd8) begin
      w_eff = 7'd8;
    end else if (crc_width_q > 7'd64) begin
      w_eff = 7'd64;
    end else begin
      w_eff = crc_width_q;
    end
    shamt_full      = 7'd64 - w_eff;
    cfg_d.shamt     = shamt_full[ccrc_pkg::ShamtW-1:0];
    cfg_d.mask      = {ccrc_pkg::CrcW{1'b1}} >> cfg_d.shamt;
    cfg_d.poly_fwd  = (poly_value_q & cfg_d.mask) << cfg_d.shamt;
    cfg_d.poly_ref  = ccrc_pkg::bit_rev64(poly_value_q & cfg_d.mask) >> cfg_d.shamt;
    cfg_d.init_m    = init_value_q & cfg_d.mask;
    cfg_d.xor_m     = xor_out_q & cfg_d.mask;
    cfg_d.reflected = reflected_mode_q;
    cfg_d.refl_in   = reflect_in_q;
    cfg_d.refl_out  = reflect_out_q;
  end

  // Settings are recomputed every cycle from the configuration registers and registered.
  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ccrc_step.sv
// One-byte CRC update (eight bit steps) and final value formation.
`timescale 1ns / 1ps

module ccrc_step (
  input  ccrc_pkg::ccrc_cfg_t            cfg_i,
  input  logic                           at_start_i,
  input  logic [ccrc_pkg::CrcW-1:0]      crc_i,
  input  logic [ccrc_pkg::ByteW-1:0]     data_i,
  output logic [ccrc_pkg::CrcW-1:0]      crc_o,
  output logic [ccrc_pkg::CrcW-1:0]      result_o
);

  logic [ccrc_pkg::CrcW-1:0]  crc0;
  logic [ccrc_pkg::ByteW-1:0] b;
  logic [ccrc_pkg::CrcW-1:0]  x;
  logic [ccrc_pkg::CrcW-1:0]  refl;

  always_comb begin
    crc0 = at_start_i ? cfg_i.init_m : (crc_i & cfg_i.mask);
    b    = cfg_i.refl_in ? ccrc_pkg::bit_rev8(data_i) : data_i;
    if (!cfg_i.reflected) begin
      // Work left-justified so the top bit is always bit 63.
      x = (crc0 << cfg_i.shamt) ^ {b, {(ccrc_pkg::CrcW-ccrc_pkg::ByteW){1'b0}}};
      for (int i = 0; i < ccrc_pkg::ByteW; i++) begin
        x = x[ccrc_pkg::CrcW-1] ? ((x << 1) ^ cfg_i.poly_fwd) : (x << 1);
      end
      crc_o = x >> cfg_i.shamt;
    end else begin
      x = crc0 ^ {{(ccrc_pkg::CrcW-ccrc_pkg::ByteW){1'b0}}, b};
      for (int i = 0; i < ccrc_pkg::ByteW; i++) begin
        x = x[0] ? ((x >> 1) ^ cfg_i.poly_ref) : (x >> 1);
      end
      crc_o = x;
    end
    refl     = ccrc_pkg::bit_rev64(crc_o) >> cfg_i.shamt;
    result_o = (cfg_i.refl_out ? refl : crc_o) ^ cfg_i.xor_m;
  end

endmodule

// File: rtl/core/configurable_crc_engine.sv
// Top level of the configurable CRC engine: handshakes, state and result register.
`timescale 1ns / 1ps

// The engine computes a parameterized CRC of width 8 to 64 bits over a byte
// stream, one byte per clock cycle sustained unless input is held off. A byte
// transfer is registered, and when it retires from the input register the
// eight bit steps of the update run in one pass of logic and write the running
// CRC register, so consecutive bytes of a message follow back to back; the
// loop through the CRC register sets this rate. A transfer with last_byte_i
// set produces one result transfer on the output channel, via the input and
// result registers, carrying the final CRC with zeros above the configured
// width. Other bytes produce nothing. The next byte after a last byte starts
// a new message from init_value. Input is held off only when a last byte sits
// in the input register while the previous result is still waiting to be
// taken. Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i and take effect for bytes accepted from the next cycle on;
// write them only while no result is pending.

module configurable_crc_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccrc_pkg::CrcW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ccrc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ccrc_pkg::CrcW-1:0]     crc_result_o
);

  ccrc_pkg::ccrc_cfg_t        cfg;

  // Input register stage.
  logic                       s1_valid_q, s1_valid_d;
  logic [ccrc_pkg::ByteW-1:0] s1_data_q;
  logic                       s1_last_q;

  // Running state of the message.
  logic [ccrc_pkg::CrcW-1:0]  crc_q;
  logic                       at_start_q;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic [ccrc_pkg::CrcW-1:0]  out_crc_q;

  logic [ccrc_pkg::CrcW-1:0]  crc_next;
  logic [ccrc_pkg::CrcW-1:0]  result_next;
  logic                       out_free;
  logic                       s1_fire;
  logic                       in_fire;

  ccrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ccrc_step u_step (
    .cfg_i      (cfg),
    .at_start_i (at_start_q),
    .crc_i      (crc_q),
    .data_i     (s1_data_q),
    .crc_o      (crc_next),
    .result_o   (result_next)
  );

  // A non-last byte always retires; a last byte needs a free result register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      at_start_q  <= 1'b1;
      crc_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        at_start_q <= s1_last_q;
        crc_q      <= crc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_fire && s1_last_q) begin
      out_crc_q <= result_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign crc_result_o = out_crc_q;

  // A result appears only after a last byte has been processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_last_q))
    else $error("result appeared without a last byte");

  // A processed last byte makes the next byte start a new message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> at_start_q)
    else $error("message start not armed after last byte");

  // A last byte blocked behind a waiting result must stall the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while last byte is blocked");

  // Bits at and above the configured width of a result are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_crc_q & ~cfg.mask) == '0))
    else $error("result has bits above the CRC width");

endmodule
